/* sv/fsnb_pkg.sv */
// Shared types, constants and character helpers for the short name builder.
`default_nettype none

package fsnb_pkg;

   localparam int unsigned NAME_LEN    = 11;
   localparam int unsigned BASE_LEN    = 8;
   localparam int unsigned EXT_LEN     = 3;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [7:0] FILL_BYTE = 8'h20;
   localparam logic [7:0] CH_END    = 8'h00;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_Z  = 8'h7A;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_UP_Z   = 8'h5A;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_TILDE  = 8'h7E;
   localparam logic [7:0] CASE_DIFF = 8'h20;

   typedef enum logic [2:0] {
      PH_BASE = 3'd0,
      PH_SKIP = 3'd1,
      PH_DOTS = 3'd2,
      PH_EXT  = 3'd3,
      PH_IDLE = 3'd4
   } fsnb_phase_type;

   typedef logic [NAME_LEN-1:0][7:0] fsnb_bytes_type;

   // one finished name waiting for the back end
   typedef struct packed {
      fsnb_bytes_type bytes;
      logic           bad;
   } fsnb_rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fsnb_qstat_type;

   function automatic logic ch_allowed(input logic [7:0] c);
      return (c >= CH_CARET && c <= CH_LOW_Z) || (c >= CH_AT && c <= CH_UP_Z) ||
             (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_QUOTE && c <= CH_RPAREN) ||
             (c >= CH_HASH && c <= CH_AMP) || c == CH_BANG || c == CH_DASH ||
             c == CH_LBRACE || c == CH_RBRACE || c == CH_TILDE;
   endfunction

   function automatic logic [7:0] ch_upper(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
         r = c - CASE_DIFF;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* sv/fat_short_name_builder.sv */
// Top level of the FAT 8.3 short name builder.
//
//   channel  direction  words                        payload
//   req_     in         one per name character       req_ch
//   rsp_     out        11 per zero character        rsp_name_byte, rsp_byte_index,
//                                                     rsp_status, rsp_name_end
//
// One character is taken per cycle while the queue is not full; the front end
// updates the name in that cycle. A zero character moves the finished name
// into a QUEUE_DEPTH-entry queue. The back end emits one byte per cycle from
// the queue head while rsp_ready allows. req_ready drops only while the queue
// is full, so names shorter than 11 characters are paced by the back end.
// Synchronous reset clears phase, counts, name (to spaces), queue and rsp_valid.
`default_nettype none

module fat_short_name_builder #(
   parameter int unsigned QUEUE_DEPTH = fsnb_pkg::QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_ch,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_name_byte,
   output logic [3:0]      rsp_byte_index,
   output logic            rsp_status,
   output logic            rsp_name_end
);
   import fsnb_pkg::*;

   fsnb_qstat_type qstat;
   fsnb_rec_type   push_rec;
   fsnb_rec_type   head_rec;
   logic           push;
   logic           pop;

   fsnb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_ch    (req_ch),
      .qstat     (qstat),
      .push      (push),
      .push_rec  (push_rec)
   );

   fsnb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .qstat    (qstat)
   );

   fsnb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_rec       (head_rec),
      .qstat          (qstat),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_name_byte  (rsp_name_byte),
      .rsp_byte_index (rsp_byte_index),
      .rsp_status     (rsp_status),
      .rsp_name_end   (rsp_name_end)
   );

   a_last_at_end : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_name_end == (rsp_byte_index == 4'(NAME_LEN - 1))))
      else $error("name end flag does not match byte index");

   a_index_steps : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_name_end) |=>
         (rsp_valid && rsp_byte_index == $past(rsp_byte_index) + 4'd1))
      else $error("byte index did not advance within a burst");

   a_status_held : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_name_end) |=> (rsp_status == $past(rsp_status)))
      else $error("status changed within a burst");

   a_burst_restarts : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_name_end) |=> (!rsp_valid || rsp_byte_index == 4'd0))
      else $error("new burst did not start at byte 0");

endmodule

`default_nettype wire

/* sv/fsnb_front.sv */
// Front end: takes characters, classifies them and builds the 11-byte name.
`default_nettype none

module fsnb_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [7:0]            req_ch,
   input  wire fsnb_pkg::fsnb_qstat_type qstat,
   output logic                       push,
   output fsnb_pkg::fsnb_rec_type     push_rec
);
   import fsnb_pkg::*;

   fsnb_phase_type phase_ff, phase_in;
   logic [3:0]     base_count_ff, base_count_in;
   logic [1:0]     ext_count_ff, ext_count_in;
   logic           invalid_ff, invalid_in;
   fsnb_bytes_type store_ff, store_in;

   logic       accept;
   logic       ok;
   logic       is_dot;
   logic       do_ext;
   logic [7:0] up;
   logic [3:0] ext_idx;
   logic [1:0] ext_next;

   assign req_ready = !qstat.full;
   assign accept    = req_valid && req_ready;
   assign ok        = ch_allowed(req_ch);
   assign up        = ch_upper(req_ch);
   assign is_dot    = (req_ch == CH_DOT);
   assign ext_idx   = 4'(BASE_LEN) + {2'b00, ext_count_ff};
   assign ext_next  = ext_count_ff + 2'd1;

   assign push_rec.bytes = store_ff;
   assign push_rec.bad   = invalid_ff || (base_count_ff == 4'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_BASE;
         base_count_ff <= '0;
         ext_count_ff  <= '0;
         invalid_ff    <= 1'b0;
         store_ff      <= {NAME_LEN{FILL_BYTE}};
      end else begin
         phase_ff      <= phase_in;
         base_count_ff <= base_count_in;
         ext_count_ff  <= ext_count_in;
         invalid_ff    <= invalid_in;
         store_ff      <= store_in;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      base_count_in = base_count_ff;
      ext_count_in  = ext_count_ff;
      invalid_in    = invalid_ff;
      store_in      = store_ff;
      push          = 1'b0;
      do_ext        = 1'b0;

      if (accept) begin
         if (req_ch == CH_END) begin
            // hand the name over and start afresh
            push          = 1'b1;
            phase_in      = PH_BASE;
            base_count_in = '0;
            ext_count_in  = '0;
            invalid_in    = 1'b0;
            store_in      = {NAME_LEN{FILL_BYTE}};
         end else begin
            case (phase_ff)
               PH_BASE: begin
                  if (is_dot) begin
                     if (base_count_ff == 4'd0) begin
                        invalid_in = 1'b1;
                        phase_in   = PH_IDLE;
                     end else begin
                        phase_in = PH_DOTS;
                     end
                  end else if (!ok) begin
                     invalid_in = 1'b1;
                     phase_in   = PH_IDLE;
                  end else if (base_count_ff < 4'(BASE_LEN)) begin
                     store_in[base_count_ff] = up;
                     base_count_in           = base_count_ff + 4'd1;
                     if (base_count_ff == 4'(BASE_LEN - 1)) begin
                        phase_in = PH_SKIP;
                     end
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
               PH_SKIP: begin
                  if (is_dot) begin
                     phase_in = PH_DOTS;
                  end
               end
               PH_DOTS: begin
                  do_ext = !is_dot;
               end
               PH_EXT: begin
                  do_ext = 1'b1;
               end
               default: begin
               end
            endcase

            if (do_ext) begin
               if (!ok) begin
                  invalid_in = 1'b1;
                  phase_in   = PH_IDLE;
               end else if (ext_count_ff < 2'(EXT_LEN)) begin
                  store_in[ext_idx] = up;
                  ext_count_in      = ext_next;
                  phase_in          = (ext_next == 2'(EXT_LEN)) ? PH_IDLE : PH_EXT;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

/* sv/fsnb_queue.sv */
// Short queue of finished names between front and back end.
`default_nettype none

module fsnb_queue #(
   parameter int unsigned DEPTH = fsnb_pkg::QUEUE_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire fsnb_pkg::fsnb_rec_type   push_rec,
   input  wire logic                     pop,
   output fsnb_pkg::fsnb_rec_type        head_rec,
   output fsnb_pkg::fsnb_qstat_type      qstat
);
   import fsnb_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   fsnb_rec_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign qstat.full  = (count_ff == CNT_W'(DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head_rec    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

`default_nettype wire

/* sv/fsnb_back.sv */
// Back end: plays a queued name out as 11 words through an output register.
`default_nettype none

module fsnb_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire fsnb_pkg::fsnb_rec_type   head_rec,
   input  wire fsnb_pkg::fsnb_qstat_type qstat,
   output logic                          pop,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [7:0]                    rsp_name_byte,
   output logic [3:0]                    rsp_byte_index,
   output logic                          rsp_status,
   output logic                          rsp_name_end
);
   import fsnb_pkg::*;

   logic [3:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic [3:0] index_ff;
   logic       status_ff;
   logic       last_ff;
   logic       load;
   logic       at_last;

   assign load    = !qstat.empty && (!valid_ff || rsp_ready);
   assign at_last = (idx_ff == 4'(NAME_LEN - 1));
   assign pop     = load && at_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = at_last ? 4'd0 : idx_ff + 4'd1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= head_rec.bytes[idx_ff];
         index_ff  <= idx_ff;
         status_ff <= head_rec.bad;
         last_ff   <= at_last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_name_byte  = byte_ff;
   assign rsp_byte_index = index_ff;
   assign rsp_status     = status_ff;
   assign rsp_name_end   = last_ff;

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the FAT 8.3 short name builder.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fsnb_pkg::*;

   localparam int unsigned CHAR_TARGET = 300;
   localparam int unsigned HOLD_CYCLES = 300;

   typedef struct packed {
      logic [7:0] nb;
      logic [3:0] idx;
      logic       st;
      logic       last;
   } name_word_type;

   // Tracks the short name being built and queues the 11 words owed per name.
   class name_scoreboard;
      fsnb_phase_type phase;
      int unsigned    base_n;
      int unsigned    ext_n;
      logic           bad;
      logic [7:0]     store [NAME_LEN];
      name_word_type  due [$];
      int unsigned    errors;
      int unsigned    names;
      int unsigned    bad_names;
      int unsigned    words;

      function new();
         clear();
      endfunction

      function void clear();
         phase  = PH_BASE;
         base_n = 0;
         ext_n  = 0;
         bad    = 1'b0;
         foreach (store[k]) store[k] = FILL_BYTE;
      endfunction

      static function logic legal(logic [7:0] c);
         if (c >= CH_CARET && c <= CH_LOW_Z) return 1'b1;
         if (c >= CH_AT && c <= CH_UP_Z) return 1'b1;
         if (c >= CH_ZERO && c <= CH_NINE) return 1'b1;
         if (c >= CH_QUOTE && c <= CH_RPAREN) return 1'b1;
         if (c >= CH_HASH && c <= CH_AMP) return 1'b1;
         return c == CH_BANG || c == CH_DASH || c == CH_LBRACE ||
                c == CH_RBRACE || c == CH_TILDE;
      endfunction

      static function logic [7:0] upcase(logic [7:0] c);
         if (c >= CH_LOW_A && c <= CH_LOW_Z) return c - CASE_DIFF;
         return c;
      endfunction

      function void mark_bad();
         bad   = 1'b1;
         phase = PH_IDLE;
      endfunction

      function void ext_char(logic [7:0] c);
         if (!legal(c)) begin
            mark_bad();
            return;
         end
         if (ext_n < EXT_LEN) begin
            store[BASE_LEN + ext_n] = upcase(c);
            ext_n++;
         end
         phase = (ext_n >= EXT_LEN) ? PH_IDLE : PH_EXT;
      endfunction

      function void note_char(logic [7:0] c);
         name_word_type w;
         logic          st;
         if (c == CH_END) begin
            st = bad || base_n == 0;
            for (int k = 0; k < NAME_LEN; k++) begin
               w.nb   = store[k];
               w.idx  = 4'(k);
               w.st   = st;
               w.last = (k == NAME_LEN - 1);
               due.push_back(w);
            end
            names++;
            if (st) bad_names++;
            clear();
            return;
         end
         case (phase)
            PH_BASE: begin
               if (c == CH_DOT) begin
                  if (base_n == 0) mark_bad();
                  else phase = PH_DOTS;
               end else if (!legal(c)) begin
                  mark_bad();
               end else begin
                  store[base_n] = upcase(c);
                  base_n++;
                  if (base_n >= BASE_LEN) phase = PH_SKIP;
               end
            end
            PH_SKIP: begin
               // unchecked until the next dot
               if (c == CH_DOT) phase = PH_DOTS;
            end
            PH_DOTS: begin
               if (c != CH_DOT) ext_char(c);
            end
            PH_EXT: begin
               ext_char(c);
            end
            default: ;
         endcase
      endfunction

      task report(string msg);
         $display("tb: mismatch: %s", msg);
         errors++;
      endtask

      task check_word(logic [7:0] nb, logic [3:0] idx, logic st, logic last);
         name_word_type w;
         if (due.size() == 0) begin
            report($sformatf("unexpected word, index %0d byte %h", idx, nb));
            return;
         end
         w = due.pop_front();
         words++;
         if (nb !== w.nb)
            report($sformatf("word %0d: byte %h, want %h", words, nb, w.nb));
         if (idx !== w.idx)
            report($sformatf("word %0d: index %0d, want %0d", words, idx, w.idx));
         if (st !== w.st)
            report($sformatf("word %0d: status %b, want %b", words, st, w.st));
         if (last !== w.last)
            report($sformatf("word %0d: name end %b, want %b", words, last, w.last));
      endtask

      function int unsigned pending();
         return due.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_ch = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_name_byte;
   logic [3:0] rsp_byte_index;
   logic       rsp_status;
   logic       rsp_name_end;

   name_scoreboard sb;
   int unsigned    chars_sent;
   bit             send_rush;

   fat_short_name_builder uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_ch         (req_ch),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_name_byte  (rsp_name_byte),
      .rsp_byte_index (rsp_byte_index),
      .rsp_status     (rsp_status),
      .rsp_name_end   (rsp_name_end)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) sb.note_char(req_ch);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_word(rsp_name_byte, rsp_byte_index, rsp_status, rsp_name_end);
   end

   // entered and left at a falling edge
   task automatic send_char(input logic [7:0] c);
      int unsigned gap;
      gap = send_rush ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_ch    <= c;
      do @(posedge clock); while (!req_ready);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   function automatic logic [7:0] pick_ok();
      logic [7:0] c;
      do c = 8'($urandom_range(CH_BANG, CH_TILDE)); while (!name_scoreboard::legal(c));
      return c;
   endfunction

   function automatic logic [7:0] pick_bad();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255));
      while (name_scoreboard::legal(c) || c == CH_DOT);
      return c;
   endfunction

   task automatic send_random_name();
      logic [7:0]  q [$];
      int unsigned kind;
      int unsigned n;
      kind = $urandom_range(0, 15);
      if (kind >= 14) begin
         // raw noise over bytes 1 to 255
         n = $urandom_range(0, 10);
         repeat (n) q.push_back(8'($urandom_range(1, 255)));
      end else begin
         n = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
         repeat (n) q.push_back(pick_ok());
         if ($urandom_range(0, 4) != 0) begin
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 3) : 1;
            repeat (n) q.push_back(CH_DOT);
            n = $urandom_range(0, 5);
            repeat (n) q.push_back(pick_ok());
         end
         if (kind == 10 || kind == 11) begin
            q[$urandom_range(0, q.size() - 1)] = pick_bad();
         end else if (kind == 12) begin
            q[$urandom_range(0, q.size() - 1)] = CH_DOT;
         end else if (kind == 13) begin
            q.push_front(CH_DOT);
         end
      end
      foreach (q[i]) send_char(q[i]);
      send_char(CH_END);
   endtask

   // receiver: random back-pressure, plus two long hold-offs
   initial begin
      int unsigned stall;
      int unsigned got;
      bit          rush;
      got  = 0;
      rush = 1'b0;
      @(negedge reset);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0) rush = !rush;
         if (got == 44 || got == 200) stall = HOLD_CYCLES;
         else stall = rush ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got++;
         @(negedge clock);
      end
   end

   initial begin
      #3_000_000;
      $display("tb: timed out, %0d words still owed", sb.pending());
      $display("tb: done, errors");
      $finish;
   end

   initial begin
      sb         = new();
      chars_sent = 0;
      send_rush  = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty name, leading dot
      send_char(CH_END);
      send_text(".");
      send_char(CH_END);
      // bad top byte after a stored one
      send_text("a");
      send_char(8'hFF);
      send_char(CH_END);
      // full base, unchecked skip, then extension
      send_text("ABCDEFGH");
      send_char(8'h80);
      send_text(".e");
      send_char(CH_END);
      // dots skipped and the extension fills
      send_text("x..a}d");
      send_char(CH_END);
      // dot inside extension
      send_text("q.a.");
      send_char(CH_END);

      while (chars_sent < CHAR_TARGET) begin
         if ($urandom_range(0, 5) == 0) send_rush = !send_rush;
         send_random_name();
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("tb: %0d characters in %0d names (%0d invalid), %0d name bytes checked",
               chars_sent, sb.names, sb.bad_names, sb.words);
      $display("tb: long and overlong bases, dot runs, full extensions, noise, %0d-cycle hold",
               HOLD_CYCLES);
      if (sb.errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end
endmodule

/* fat_short_name_builder.f */
sv/fsnb_pkg.sv
sv/fsnb_front.sv
sv/fsnb_queue.sv
sv/fsnb_back.sv
sv/fat_short_name_builder.sv
verif/tb.sv
